// ===== rtl/srcmp_pkg.sv =====
package srcmp_pkg;

    localparam int VAL_W = 32;
    localparam int ACC_W = 48;
    localparam int SEED_W = 16;
    localparam int CFG_IDX_W = 8;
    localparam int HALF_W = ACC_W / 2;
    localparam int PART_W = SEED_W + HALF_W;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SEED_FRACTION = CFG_IDX_W'(1);

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_MAX_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MAX_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    // configuration as seen by the element datapath
    typedef struct packed {
        logic [ACC_W-1:0] step;
        logic [ACC_W-1:0] seed_thr;
    } cfg_t;

    // one result beat
    typedef struct packed {
        logic [VAL_W-1:0] new_value;
        logic             keep_out;
        logic [ACC_W-1:0] kept_norm;
        logic             last_out;
    } result_t;

    // saturating accumulator add
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

endpackage

// ===== rtl/srcmp_cfg.sv =====
module srcmp_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [srcmp_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [srcmp_pkg::ACC_W-1:0]     wr_data,
    output srcmp_pkg::cfg_t                 cfg
);
    import srcmp_pkg::*;

    logic [ACC_W-1:0]  step_reg, step_next;
    logic [SEED_W-1:0] seed_reg, seed_next;
    logic [PART_W-1:0] part_lo_reg, part_hi_reg;
    logic [ACC_W-1:0]  seed_thr_reg, seed_thr_next;

    always_comb begin
        step_next = step_reg;
        seed_next = seed_reg;
        if (wr_en && wr_index == REG_SAMPLE_STEP) begin
            step_next = wr_data;
        end
        if (wr_en && wr_index == REG_SEED_FRACTION) begin
            seed_next = wr_data[SEED_W-1:0];
        end
    end

    // (hi << 24 + lo) >> 16 == (hi << 8) + (lo >> 16), the product is below 2^64
    assign seed_thr_next = {part_hi_reg, {(HALF_W-SEED_W){1'b0}}}
                         + ACC_W'(part_lo_reg[PART_W-1:SEED_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            seed_reg     <= '0;
            part_lo_reg  <= '0;
            part_hi_reg  <= '0;
            seed_thr_reg <= '0;
        end else begin
            step_reg     <= step_next;
            seed_reg     <= seed_next;
            // two narrow partial products of seed times step
            part_lo_reg  <= seed_next * step_next[HALF_W-1:0];
            part_hi_reg  <= seed_next * step_next[ACC_W-1:HALF_W];
            seed_thr_reg <= seed_thr_next;
        end
    end

    assign cfg.step     = step_reg;
    assign cfg.seed_thr = seed_thr_reg;

endmodule

// ===== rtl/srcmp_core.sv =====
module srcmp_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [srcmp_pkg::VAL_W-1:0] elem_value,
    input  logic                        keep_in,
    input  logic                        last_in,
    input  srcmp_pkg::cfg_t             cfg,
    output srcmp_pkg::result_t          result
);
    import srcmp_pkg::*;

    logic [ACC_W-1:0] lb_reg, lb_next;
    logic [ACC_W-1:0] thr_reg, thr_next;
    logic [ACC_W-1:0] norm_reg, norm_next;
    logic             in_vec_reg;

    logic [ACC_W-1:0] lb0, thr0, norm0, magn, lb_sum;
    logic [VAL_W-1:0] abs_val;
    logic [VAL_W-1:0] value;
    logic             neg, keep_out;

    // magnitude taken at element width, then widened to the accumulators
    assign neg     = elem_value[VAL_W-1];
    assign abs_val = neg ? (~elem_value + VAL_W'(1)) : elem_value;
    assign magn    = ACC_W'(abs_val);

    // a new vector restarts from cleared sums and the seeded threshold
    assign lb0   = in_vec_reg ? lb_reg   : '0;
    assign norm0 = in_vec_reg ? norm_reg : '0;
    assign thr0  = in_vec_reg ? thr_reg  : cfg.seed_thr;
    assign lb_sum = sat_add(lb0, magn);

    always_comb begin
        lb_next   = lb0;
        thr_next  = thr0;
        norm_next = norm0;
        value     = elem_value;
        keep_out  = 1'b0;
        priority if (keep_in) begin
            norm_next = sat_add(norm0, magn);
        end else if (elem_value != '0) begin
            lb_next = lb_sum;
            if (cfg.step != '0 && thr0 < lb_sum) begin
                if (neg) begin
                    value = (cfg.step >= ACC_W'(VAL_MAX_NEG)) ? VAL_MAX_NEG
                          : (~cfg.step[VAL_W-1:0] + VAL_W'(1));
                end else begin
                    value = (cfg.step > ACC_W'(VAL_MAX_POS)) ? VAL_MAX_POS
                          : cfg.step[VAL_W-1:0];
                end
                norm_next = sat_add(norm0, cfg.step);
                thr_next  = sat_add(thr0, cfg.step);
            end else begin
                value    = '0;
                keep_out = 1'b1;
            end
        end else begin
            // zero unflagged element passes through, sums unchanged
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lb_reg     <= '0;
            thr_reg    <= '0;
            norm_reg   <= '0;
            in_vec_reg <= 1'b0;
        end else if (advance) begin
            lb_reg     <= lb_next;
            thr_reg    <= thr_next;
            norm_reg   <= norm_next;
            in_vec_reg <= !last_in;
        end
    end

    assign result.new_value = value;
    assign result.keep_out  = keep_out;
    assign result.kept_norm = norm_next;
    assign result.last_out  = last_in;

endmodule

// ===== rtl/systematic_resample_compress.sv =====
// systematic resampling compressor: a vector streams in one element per beat,
// signed q16.16, with tuser flagging elements kept exactly and tlast marking
// the final element. kept elements pass unchanged; other nonzero elements are
// either replaced by sign times sample_step or zeroed and flagged in m_tuser,
// and every result beat carries the running one-norm of the output so far
// (q32.16, saturating). one element is accepted per cycle unless m_tready
// stalls the output, via input and output registers; the rate is set by the
// single saturating add and compare on the running lower bound and threshold.
// the user must write configuration only while the stream is idle, unchecked;
// the seeded threshold is ready for an element taken the cycle after a write.
module systematic_resample_compress (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srcmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srcmp_pkg::ACC_W-1:0]     cfg_data,
    // element stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // elem_value[31:0]
    input  logic                            s_tuser,   // keep_in
    input  logic                            s_tlast,   // last_in
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [79:0]                     m_tdata,   // new_value[31:0], kept_norm[79:32]
    output logic                            m_tuser,   // keep_out
    output logic                            m_tlast    // last_out
);
    import srcmp_pkg::*;

    cfg_t    cfg;
    result_t result;

    // input register
    logic             in_valid_reg;
    logic [VAL_W-1:0] in_value_reg;
    logic             in_keep_reg;
    logic             in_last_reg;

    // output register
    logic             out_valid_reg;
    result_t          out_reg;

    logic out_free;
    logic advance;

    // config is always taken
    assign cfg_ready = 1'b1;

    // the output register frees up when empty or when its beat is taken
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    srcmp_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    srcmp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .elem_value (in_value_reg),
        .keep_in    (in_keep_reg),
        .last_in    (in_last_reg),
        .cfg        (cfg),
        .result     (result)
    );

    // input beat capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_value_reg <= s_tdata;
            in_keep_reg  <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // result beat capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.kept_norm, out_reg.new_value};
    assign m_tuser  = out_reg.keep_out;
    assign m_tlast  = out_reg.last_out;

endmodule
